FILE: rtl/core/page_frame_allocator_refcount_assert.svh
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH

// Same-cycle check: whenever the antecedent holds, the consequent holds too.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: the consequent holds in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

  localparam int PAGE_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;
  localparam int STATUS_W  = 2;
  localparam int CNTOUT_W  = 16;
  localparam int AVAIL_W   = 11;

  localparam logic [PAGE_W-1:0] HIGHEST_RESET   = 10'd1023;
  localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 10'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGHEST = 2'd0,
    CFG_THRESH  = 2'd1
  } pfa_cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_REF   = 3'd1,
    OP_DEREF = 3'd2,
    OP_READ  = 3'd3,
    OP_ZERO  = 3'd4
  } pfa_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_CNT_ERR = 2'd3
  } pfa_status_t;

  typedef enum logic [1:0] {
    PS_CLEAR = 2'd0,
    PS_IDLE  = 2'd1,
    PS_EXEC  = 2'd2
  } pfa_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/page_frame_allocator_refcount.sv
// An accepted input beat is registered with its count and link memory reads, then
// executed in PS_EXEC once the output register is free; its result is registered.
// A new item is taken only in PS_IDLE, once the previous one has been written back.
// Reset: synchronous, active low; afterwards a clearing pass over every page
// sets every count to one while in_ready stays low. Configuration writes are taken.
`default_nettype none

module page_frame_allocator_refcount
  import pfa_pkg::*;
#(
  parameter int PAGE_COUNT = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [PAGE_W-1:0]     in_page,
  input  wire logic                  in_for_system,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [PAGE_W-1:0]          out_result_page,
  output logic                       out_needs_clear,
  output logic [CNTOUT_W-1:0]        out_count_value,
  output logic                       out_zero_wake,
  output logic [AVAIL_W-1:0]         out_available_pages
);

  localparam int AW = $clog2(PAGE_COUNT);
  localparam int SW = $clog2(PAGE_COUNT + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [AW-1:0] CLR_LAST = AW'(PAGE_COUNT - 1);

  logic [COUNT_BITS-1:0] cnt_mem [PAGE_COUNT];
  logic [PAGE_W-1:0]     lnk_mem [PAGE_COUNT];

  pfa_state_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r;
  logic clearing, done;

  logic [2:0]        op_r;
  logic [PAGE_W-1:0] page_r;
  logic              sys_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [PAGE_W-1:0]     lnk_rd_r;
  logic [AW-1:0] cnt_ra, lnk_ra;

  logic [PAGE_W-1:0] highest_r;
  logic [CFG_W-1:0]  thresh_r;

  logic [PAGE_W-1:0] fh_r, ft_r, zh_r, zt_r;
  logic [PAGE_W-1:0] fh_nxt, ft_nxt, zh_nxt, zt_nxt;
  logic [SW-1:0]     fsz_r, zsz_r, fsz_nxt, zsz_nxt;
  logic              wake_r, wake_nxt;

  logic [STATUS_W-1:0]   res_status;
  logic [PAGE_W-1:0]     res_page;
  logic                  res_clear;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_wake;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  lnk_we;
  logic [AW-1:0]         lnk_wa;
  logic [PAGE_W-1:0]     lnk_wd;

  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
  logic page_big, lists_full, free_grows_past;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PAGE_W-1:0]     out_page_r;
  logic                  out_clear_r;
  logic [CNTOUT_W-1:0]   out_cnt_r;
  logic                  out_wake_r;
  logic [AVAIL_W-1:0]    out_avail_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PS_CLEAR: if (clr_idx_r == CLR_LAST) state_nxt = PS_IDLE;
      PS_IDLE:  if (in_valid) state_nxt = PS_EXEC;
      PS_EXEC:  if (done) state_nxt = PS_IDLE;
      default:  state_nxt = PS_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = (state_r == PS_IDLE);
    clearing = (state_r == PS_CLEAR);
    done     = (state_r == PS_EXEC) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= PS_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  assign cnt_ra = (in_opcode == OP_ZERO) ? AW'(fh_r) : AW'(in_page);
  assign lnk_ra = ((in_opcode == OP_ALLOC) && (zsz_r != '0)) ? AW'(zh_r) : AW'(fh_r);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      page_r <= in_page;
      sys_r  <= in_for_system;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      cnt_mem[clr_idx_r] <= CNT_ONE;
    end else if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (in_valid && in_ready) cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (in_valid && in_ready) lnk_rd_r <= lnk_mem[lnk_ra];
  end

  assign cnt_inc  = cnt_rd_r + CNT_ONE;
  assign cnt_dec  = cnt_rd_r - CNT_ONE;
  assign page_big = 32'(page_r) >= 32'(PAGE_COUNT);
  assign lists_full = (32'(fsz_r) + 32'(zsz_r)) >= 32'(PAGE_COUNT);
  assign free_grows_past = (32'(fsz_r) + 32'd1) > 32'(thresh_r);

  always_comb begin
    fh_nxt = fh_r;
    ft_nxt = ft_r;
    zh_nxt = zh_r;
    zt_nxt = zt_r;
    fsz_nxt = fsz_r;
    zsz_nxt = zsz_r;
    wake_nxt = wake_r;
    res_status = STAT_OK;
    res_page = '0;
    res_clear = 1'b0;
    res_cnt = '0;
    res_wake = 1'b0;
    cnt_we = 1'b0;
    cnt_wa = AW'(page_r);
    cnt_wd = cnt_dec;
    lnk_we = 1'b0;
    lnk_wa = AW'(ft_r);
    lnk_wd = page_r;
    case (op_r)
      OP_ALLOC: begin
        if (zsz_r != '0) begin
          res_page = zh_r;
          if (zsz_r > SW'(1)) zh_nxt = lnk_rd_r;
          zsz_nxt = zsz_r - SW'(1);
        end else if (fsz_r != '0) begin
          res_page = fh_r;
          if (fsz_r > SW'(1)) fh_nxt = lnk_rd_r;
          fsz_nxt = fsz_r - SW'(1);
          res_clear = !sys_r;
        end else begin
          res_status = STAT_EMPTY;
        end
        if (res_status == STAT_OK) begin
          cnt_we = 1'b1;
          cnt_wa = AW'(res_page);
          cnt_wd = CNT_ONE;
          res_cnt = CNT_ONE;
        end
      end
      OP_REF: begin
        if ((page_r == '0) || (page_r > highest_r) || page_big) begin
          res_status = STAT_IGNORED;
        end else if (cnt_rd_r == CNT_MAX) begin
          res_status = STAT_CNT_ERR;
          res_cnt = cnt_rd_r;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = cnt_inc;
          res_cnt = cnt_inc;
        end
      end
      OP_DEREF: begin
        if (page_big) begin
          res_status = STAT_IGNORED;
        end else if (cnt_rd_r == '0) begin
          res_status = STAT_CNT_ERR;
        end else begin
          cnt_we = 1'b1;
          res_cnt = cnt_dec;
          if (cnt_dec == '0) begin
            if (lists_full) begin
              res_status = STAT_CNT_ERR;
            end else begin
              if (fsz_r == '0) fh_nxt = page_r;
              else lnk_we = 1'b1;
              ft_nxt = page_r;
              fsz_nxt = fsz_r + SW'(1);
              if (free_grows_past && !wake_r) begin
                wake_nxt = 1'b1;
                res_wake = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        if (page_big) res_status = STAT_IGNORED;
        else res_cnt = cnt_rd_r;
      end
      OP_ZERO: begin
        if (fsz_r == '0) begin
          res_status = STAT_EMPTY;
          wake_nxt = 1'b0;
        end else begin
          res_page = fh_r;
          if (fsz_r > SW'(1)) fh_nxt = lnk_rd_r;
          fsz_nxt = fsz_r - SW'(1);
          if (zsz_r == '0) begin
            zh_nxt = fh_r;
          end else begin
            lnk_we = 1'b1;
            lnk_wa = AW'(zt_r);
            lnk_wd = fh_r;
          end
          zt_nxt = fh_r;
          zsz_nxt = zsz_r + SW'(1);
          res_clear = 1'b1;
          res_cnt = cnt_rd_r;
          if (fsz_r == SW'(1)) wake_nxt = 1'b0;
        end
      end
      default: res_status = STAT_IGNORED;
    endcase
    if (!done) begin
      cnt_we = 1'b0;
      lnk_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r <= HIGHEST_RESET;
      thresh_r  <= THRESHOLD_RESET;
      fh_r <= '0;
      ft_r <= '0;
      zh_r <= '0;
      zt_r <= '0;
      fsz_r <= '0;
      zsz_r <= '0;
      wake_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_HIGHEST)) highest_r <= cfg_wdata;
      if (cfg_we && (cfg_index == CFG_THRESH))  thresh_r  <= cfg_wdata;
      if (done) begin
        fh_r <= fh_nxt;
        ft_r <= ft_nxt;
        zh_r <= zh_nxt;
        zt_r <= zt_nxt;
        fsz_r <= fsz_nxt;
        zsz_r <= zsz_nxt;
        wake_r <= wake_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= res_status;
      out_page_r   <= res_page;
      out_clear_r  <= res_clear;
      out_cnt_r    <= CNTOUT_W'(res_cnt);
      out_wake_r   <= res_wake;
      out_avail_r  <= AVAIL_W'(32'(fsz_nxt) + 32'(zsz_nxt));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_page     = out_page_r;
  assign out_needs_clear     = out_clear_r;
  assign out_count_value     = out_cnt_r;
  assign out_zero_wake       = out_wake_r;
  assign out_available_pages = out_avail_r;

`include "page_frame_allocator_refcount_assert.svh"

  `PFA_ASSERT_NOW(a_no_accept_clearing, clearing, !in_ready,
    "input beat offered ready during the clearing pass")
  `PFA_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == PS_EXEC,
    "accepted beat did not start execution")
  `PFA_ASSERT_NEXT(a_done_gives_result, done, out_valid_r,
    "completed item produced no result beat")
  `PFA_ASSERT_NOW(a_lists_bounded, 1'b1,
    (32'(fsz_r) + 32'(zsz_r)) <= 32'(PAGE_COUNT),
    "list sizes exceed the page count")

endmodule

`default_nettype wire

FILE: dv/page_frame_allocator_refcount_tb.sv
`timescale 1ns / 100ps

module page_frame_allocator_refcount_tb
  import pfa_pkg::*;
();

  localparam int PAGES = 1024;
  localparam logic [CNTOUT_W-1:0] COUNT_MAX = '1;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int FREE_LIST = 0;
  localparam int ZEROED_LIST = 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 600;
  localparam int RUN_LIMIT_NS = 4000000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic                clear;
    logic [CNTOUT_W-1:0] count;
    logic                wake;
    logic [AVAIL_W-1:0]  avail;
  } page_outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_opcode;
  logic [PAGE_W-1:0]    in_page;
  logic                 in_for_system;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [PAGE_W-1:0]    out_result_page;
  logic                 out_needs_clear;
  logic [CNTOUT_W-1:0]  out_count_value;
  logic                 out_zero_wake;
  logic [AVAIL_W-1:0]   out_available_pages;

  // Shadow copy of the allocator state.
  logic [CNTOUT_W-1:0] ref_cnt [PAGES];
  logic [PAGE_W-1:0]   link_mem [PAGES];
  logic [PAGE_W-1:0]   list_head [2];
  logic [PAGE_W-1:0]   list_tail [2];
  logic [AVAIL_W-1:0]  list_size [2];
  logic                wake_pend;
  logic [PAGE_W-1:0]   highest_pg;
  logic [CFG_W-1:0]    wake_thresh;

  page_outcome_t     pending_outcomes [$];
  page_outcome_t     last_outcome;
  logic [PAGE_W-1:0] held_pages [$];
  int                errors = 0;
  int                gap_max = 0;
  int                burst_left = 0;
  int                stall_pct = 0;
  logic              hold_req;

  page_frame_allocator_refcount u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_page             (in_page),
    .in_for_system       (in_for_system),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_result_page     (out_result_page),
    .out_needs_clear     (out_needs_clear),
    .out_count_value     (out_count_value),
    .out_zero_wake       (out_zero_wake),
    .out_available_pages (out_available_pages)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [PAGE_W-1:0] pop_list(input int l);
    logic [PAGE_W-1:0] pg;
    pg = list_head[l];
    if (list_size[l] > 1) begin
      list_head[l] = link_mem[pg];
    end
    list_size[l] = list_size[l] - 1'b1;
    return pg;
  endfunction

  function automatic void push_list(input int l, input logic [PAGE_W-1:0] pg);
    if (list_size[l] == 0) begin
      list_head[l] = pg;
    end else begin
      link_mem[list_tail[l]] = pg;
    end
    list_tail[l] = pg;
    list_size[l] = list_size[l] + 1'b1;
  endfunction

  function automatic page_outcome_t page_op_outcome(input logic [2:0] op,
                                                    input logic [PAGE_W-1:0] pg,
                                                    input logic sys);
    page_outcome_t r;
    logic [PAGE_W-1:0] taken;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_ALLOC: begin
        if (list_size[ZEROED_LIST] != 0) begin
          taken = pop_list(ZEROED_LIST);
          r.page = taken;
          ref_cnt[taken] = 1;
          r.count = 1;
        end else if (list_size[FREE_LIST] != 0) begin
          taken = pop_list(FREE_LIST);
          r.page = taken;
          r.clear = !sys;
          ref_cnt[taken] = 1;
          r.count = 1;
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      OP_REF: begin
        if (pg == 0 || pg > highest_pg) begin
          r.status = STAT_IGNORED;
        end else begin
          if (ref_cnt[pg] == COUNT_MAX) begin
            r.status = STAT_CNT_ERR;
          end else begin
            ref_cnt[pg] = ref_cnt[pg] + 1'b1;
          end
          r.count = ref_cnt[pg];
        end
      end
      OP_DEREF: begin
        if (ref_cnt[pg] == 0) begin
          r.status = STAT_CNT_ERR;
        end else begin
          ref_cnt[pg] = ref_cnt[pg] - 1'b1;
          r.count = ref_cnt[pg];
          if (ref_cnt[pg] == 0) begin
            if (list_size[FREE_LIST] + list_size[ZEROED_LIST] >= PAGES) begin
              r.status = STAT_CNT_ERR;
            end else begin
              push_list(FREE_LIST, pg);
              if (list_size[FREE_LIST] > wake_thresh && !wake_pend) begin
                wake_pend = 1'b1;
                r.wake = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        r.count = ref_cnt[pg];
      end
      OP_ZERO: begin
        if (list_size[FREE_LIST] == 0) begin
          r.status = STAT_EMPTY;
          wake_pend = 1'b0;
        end else begin
          taken = pop_list(FREE_LIST);
          push_list(ZEROED_LIST, taken);
          r.page = taken;
          r.clear = 1'b1;
          r.count = ref_cnt[taken];
          if (list_size[FREE_LIST] == 0) begin
            wake_pend = 1'b0;
          end
        end
      end
      default: begin
        r.status = STAT_IGNORED;
      end
    endcase
    r.avail = list_size[FREE_LIST] + list_size[ZEROED_LIST];
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 55 && held_pages.size() != 0) begin
      return held_pages[$urandom_range(held_pages.size() - 1, 0)];
    end
    if (sel < 63) begin
      return '0;
    end
    if (sel < 70) begin
      return '1;
    end
    if (sel < 80) begin
      return highest_pg + PAGE_W'($urandom_range(1, 0));
    end
    return PAGE_W'($urandom_range(PAGES - 1, 0));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Each beat is predicted at the edge where it is accepted.
  task automatic send_item(input logic [2:0] op, input logic [PAGE_W-1:0] pg,
                           input logic sys);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_page <= pg;
    in_for_system <= sys;
    do @(posedge clk); while (!in_ready);
    last_outcome = page_op_outcome(op, pg, sys);
    pending_outcomes.push_back(last_outcome);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] highest, input logic [CFG_W-1:0] thresh);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HIGHEST;
    cfg_wdata <= highest;
    @(posedge clk);
    cfg_index <= CFG_THRESH;
    cfg_wdata <= thresh;
    @(posedge clk);
    cfg_we <= 1'b0;
    highest_pg = highest;
    wake_thresh = thresh;
  endtask

  task automatic send_random_item();
    int sel;
    logic [2:0] op;
    logic [PAGE_W-1:0] pg;
    logic sys;
    sel = $urandom_range(99, 0);
    pg = pick_page();
    sys = 1'($urandom_range(1, 0));
    if (sel < 24) begin
      op = OP_ALLOC;
    end else if (sel < 46) begin
      op = OP_DEREF;
    end else if (sel < 62) begin
      op = OP_REF;
    end else if (sel < 74) begin
      op = OP_READ;
    end else if (sel < 96) begin
      op = OP_ZERO;
    end else begin
      op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    end
    send_item(op, pg, sys);
    if (op == OP_ALLOC && last_outcome.status == STAT_OK) begin
      held_pages.push_back(last_outcome.page);
      if (held_pages.size() > 24) begin
        void'(held_pages.pop_front());
      end
    end
  endtask

  task automatic test_directed();
    int op;
    gap_max = 3;
    stall_pct = 20;
    send_item(OP_ALLOC, 10'h3FF, 1'b0);
    send_item(OP_ZERO, 10'h000, 1'b1);
    send_item(OP_REF, 10'd0, 1'b0);
    send_item(OP_REF, 10'd1023, 1'b1);
    send_item(OP_READ, 10'd1023, 1'b0);
    send_item(OP_DEREF, 10'd1023, 1'b0);
    send_item(OP_DEREF, 10'd1023, 1'b1);
    send_item(OP_DEREF, 10'd1023, 1'b0);
    send_item(OP_READ, 10'd0, 1'b1);
    send_item(OP_DEREF, 10'd0, 1'b0);
    send_item(OP_ZERO, 10'h2AA, 1'b0);
    send_item(OP_ALLOC, 10'h155, 1'b1);
    send_item(OP_ALLOC, 10'd0, 1'b0);
    send_item(OP_ALLOC, 10'd1023, 1'b0);
    for (op = OP_RSVD_LO; op <= OP_RSVD_HI; op++) begin
      send_item(3'(op), 10'd1023, 1'b1);
    end
    settle();
    write_regs(10'd1, 10'd0);
    send_item(OP_REF, 10'd2, 1'b0);
    send_item(OP_REF, 10'd1, 1'b0);
    send_item(OP_DEREF, 10'd1, 1'b0);
    send_item(OP_DEREF, 10'd1, 1'b1);
    send_item(OP_ZERO, 10'd0, 1'b0);
    send_item(OP_DEREF, 10'd1023, 1'b0);
    send_item(OP_ZERO, 10'd1023, 1'b1);
    settle();
  endtask

  // Frees pages until both lists together hold every slot, then frees one more page.
  task automatic test_lists_full();
    int pg;
    write_regs(HIGHEST_RESET, THRESHOLD_RESET);
    pg = 0;
    while (list_size[FREE_LIST] + list_size[ZEROED_LIST] < PAGES) begin
      if (ref_cnt[pg] == 0 && pg != 0) begin
        send_item(OP_REF, PAGE_W'(pg), 1'($urandom_range(1, 0)));
      end
      if (ref_cnt[pg] == 1) begin
        send_item(OP_DEREF, PAGE_W'(pg), 1'($urandom_range(1, 0)));
      end
      pg = (pg + 1) % PAGES;
    end
    if (ref_cnt[1] == 0) begin
      send_item(OP_REF, 10'd1, 1'b0);
    end
    while (ref_cnt[1] != 0) begin
      send_item(OP_DEREF, 10'd1, 1'b0);
    end
    send_item(OP_DEREF, 10'd1, 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    stall_pct = 0;
    hold_req <= ~hold_req;
    repeat (40) send_random_item();
    settle();
  endtask

  task automatic test_random_phases();
    int ph;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] th;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          hi = HIGHEST_RESET;
          th = '0;
          gap_max = 4;
          stall_pct = 25;
        end
        1: begin
          hi = 10'd1;
          th = '1;
          gap_max = 8;
          stall_pct = 40;
        end
        2: begin
          hi = HIGHEST_RESET;
          th = THRESHOLD_RESET;
          gap_max = 0;
          stall_pct = 0;
        end
        3: begin
          hi = CFG_W'($urandom_range(PAGES - 1, 0));
          th = CFG_W'($urandom_range(15, 0));
          gap_max = 2;
          stall_pct = 10;
        end
        default: begin
          hi = CFG_W'($urandom_range(PAGES - 1, 0));
          th = CFG_W'($urandom_range(PAGES - 1, 0));
          gap_max = 6;
          stall_pct = 30;
        end
      endcase
      write_regs(hi, th);
      repeat (RANDOM_ITEMS / 5) send_random_item();
      settle();
    end
  endtask

  initial begin : result_sink
    int hold_left;
    int stall_left;
    logic hold_seen;
    page_outcome_t want;
    hold_left = 0;
    stall_left = 0;
    hold_seen = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result beat with nothing pending, status %0d page %0d count %0d",
                     $time, out_status, out_result_page, out_count_value);
          end
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("result_page", 32'(want.page), 32'(out_result_page));
          check_field("needs_clear", 32'(want.clear), 32'(out_needs_clear));
          check_field("count_value", 32'(want.count), 32'(out_count_value));
          check_field("zero_wake", 32'(want.wake), 32'(out_zero_wake));
          check_field("available_pages", 32'(want.avail), 32'(out_available_pages));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
          stall_left = $urandom_range(6, 1);
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL page_frame_allocator_refcount");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HIGHEST;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_opcode <= OP_ALLOC;
    in_page <= '0;
    in_for_system <= 1'b0;
    hold_req <= 1'b0;
    for (i = 0; i < PAGES; i++) begin
      ref_cnt[i] = 1;
      link_mem[i] = '0;
    end
    for (i = 0; i < 2; i++) begin
      list_head[i] = '0;
      list_tail[i] = '0;
      list_size[i] = '0;
    end
    wake_pend = 1'b0;
    highest_pg = HIGHEST_RESET;
    wake_thresh = THRESHOLD_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_lists_full();
    test_backpressure();
    test_random_phases();
    stall_pct = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS page_frame_allocator_refcount");
    end else begin
      $display("FAIL page_frame_allocator_refcount");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pfa_pkg.sv
rtl/core/page_frame_allocator_refcount.sv
dv/page_frame_allocator_refcount_tb.sv
